>>> src/mcap_pkg.sv
// Package for the planar reflection camera pipeline.
// Types, widths and register index codes; no dependencies.
`default_nettype none
package mcap_pkg;
	localparam int CoordW = 32;
	localparam int FarW = 31;
	localparam int RatioBits = 30;
	localparam int CfgIdxW = 3;
	localparam int FlushEps = 66;
	localparam int DistW = 50;

	typedef enum logic [CfgIdxW-1:0] {
		REG_PPX = 3'd0, REG_PPY = 3'd1, REG_PPZ = 3'd2,
		REG_NX = 3'd3, REG_NY = 3'd4, REG_NZ = 3'd5, REG_FAR = 3'd6, REG_NONE = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [CoordW-1:0] ppx, ppy, ppz;
		logic signed [CoordW-1:0] nx, ny, nz;
		logic [FarW-1:0] far_d;
	} plane_cfg_t;

	function automatic logic signed [CoordW-1:0] sat32(input logic signed [69:0] x);
		logic signed [69:0] hi, lo;
		hi = 70'sd2147483647;
		lo = -70'sd2147483648;
		if (x > hi) return 32'sh7fffffff;
		else if (x < lo) return 32'sh80000000;
		else return x[CoordW-1:0];
	endfunction
endpackage
`default_nettype wire

>>> src/mcap_div.sv
// Restoring divider stage: RatioBits quotient bits, one per pipeline stage.
// Depends on mcap_pkg.
`default_nettype none
module mcap_div import mcap_pkg::*; (
	input wire logic clk,
	input wire logic en,
	input wire logic [DistW-1:0] num,
	input wire logic [DistW-1:0] den,
	output logic [RatioBits-1:0] quo
);
	logic [DistW:0] rem_q [RatioBits+1];
	logic [DistW-1:0] den_q [RatioBits+1];
	logic [RatioBits-1:0] q_q [RatioBits+1];
	logic [DistW:0] sh [RatioBits];

	always_comb begin
		rem_q[0] = {1'b0, num};
		den_q[0] = den;
		q_q[0] = '0;
	end

	for (genvar i = 0; i < RatioBits; i++) begin : g_st
		assign sh[i] = {rem_q[i][DistW-1:0], 1'b0};
		always_ff @(posedge clk) begin
			if (en) begin
				den_q[i+1] <= den_q[i];
				if (sh[i] >= {1'b0, den_q[i]}) begin
					rem_q[i+1] <= sh[i] - {1'b0, den_q[i]};
					q_q[i+1] <= {q_q[i][RatioBits-2:0], 1'b1};
				end else begin
					rem_q[i+1] <= sh[i];
					q_q[i+1] <= {q_q[i][RatioBits-2:0], 1'b0};
				end
			end
		end
	end
	assign quo = q_q[RatioBits];
endmodule
`default_nettype wire

>>> src/mirror_camera_about_plane_top.sv
// Top level of the planar reflection camera pipeline.
// Depends on mcap_pkg and mcap_div.
// channel | dir | fields (low bit first)
// s_axis  | in  | cam_pos_x, y, z, cam_front_x, y, z (192 bits)
// m_axis  | out | tuser: reflected; tdata: new_look_x,y,z, new_pos_x,y,z (192 bits)
// cfg     | in  | cfg_we, cfg_idx, cfg_data
// One word per cycle, except while the pipe stalls.
// A global enable moves the whole pipe; it stalls only when the output word is held.
// Reset clears valid bits and loads the plane registers with their defaults.
`default_nettype none
module mirror_camera_about_plane_top import mcap_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [191:0] s_axis_tdata, // cam_pos_x,y,z, cam_front_x,y,z
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [191:0] m_axis_tdata, // new_look_x,y,z, new_pos_x,y,z
	output logic m_axis_tuser, // reflected
	input wire logic cfg_we,
	input wire logic [CfgIdxW-1:0] cfg_idx,
	input wire logic [CoordW-1:0] cfg_data
);
	localparam int DivLat = RatioBits;
	localparam int Lat = DivLat + 11;

	plane_cfg_t cfg_q;
	logic signed [CoordW-1:0] nrm [3], ppt [3];
	logic en;
	logic [Lat-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{ppx: '0, ppy: '0, ppz: '0, nx: '0, ny: 32'sd65536, nz: '0,
				far_d: 31'd65536000};
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				REG_PPX: cfg_q.ppx <= cfg_data;
				REG_PPY: cfg_q.ppy <= cfg_data;
				REG_PPZ: cfg_q.ppz <= cfg_data;
				REG_NX: cfg_q.nx <= cfg_data;
				REG_NY: cfg_q.ny <= cfg_data;
				REG_NZ: cfg_q.nz <= cfg_data;
				REG_FAR: cfg_q.far_d <= cfg_data[FarW-1:0];
				default: ;
			endcase
		end
	end
	assign nrm[0] = cfg_q.nx;
	assign nrm[1] = cfg_q.ny;
	assign nrm[2] = cfg_q.nz;
	assign ppt[0] = cfg_q.ppx;
	assign ppt[1] = cfg_q.ppy;
	assign ppt[2] = cfg_q.ppz;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[Lat-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
	end

	// stage 1: front*far product
	logic signed [CoordW-1:0] pos_s1 [3];
	logic signed [63:0] ff_s1 [3];
	// stage 2: far point, differences
	logic signed [CoordW-1:0] pos_s2 [3], va_s2 [3];
	logic signed [32:0] da_s2 [3], db_s2 [3];
	// stage 3: products with normal
	logic signed [CoordW-1:0] pos_s3 [3], va_s3 [3];
	logic signed [64:0] pa_s3 [3], pb_s3 [3];
	// stage 4: distances, flush
	logic signed [CoordW-1:0] pos_s4 [3], va_s4 [3];
	logic signed [DistW-1:0] dA_s4, dB_s4;
	logic cross_s4;

	for (genvar i = 0; i < 3; i++) begin : g_front
		always_ff @(posedge clk) begin
			if (en) begin
				pos_s1[i] <= s_axis_tdata[i*32 +: 32];
				ff_s1[i] <= $signed(s_axis_tdata[(i+3)*32 +: 32]) * $signed({1'b0, cfg_q.far_d});
				pos_s2[i] <= pos_s1[i];
				va_s2[i] <= sat32(70'(pos_s1[i]) + 70'(ff_s1[i] >>> 16));
				db_s2[i] <= 33'(pos_s1[i]) - 33'(ppt[i]);
				pos_s3[i] <= pos_s2[i];
				va_s3[i] <= va_s2[i];
				pa_s3[i] <= da_s2[i] * nrm[i];
				pb_s3[i] <= db_s2[i] * nrm[i];
				pos_s4[i] <= pos_s3[i];
				va_s4[i] <= va_s3[i];
			end
		end
		assign da_s2[i] = 33'(va_s2[i]) - 33'(ppt[i]);
	end

	logic signed [DistW-1:0] sa, sb, fa, fb;
	always_comb begin
		sa = DistW'(pa_s3[0] >>> 16) + DistW'(pa_s3[1] >>> 16) + DistW'(pa_s3[2] >>> 16);
		sb = DistW'(pb_s3[0] >>> 16) + DistW'(pb_s3[1] >>> 16) + DistW'(pb_s3[2] >>> 16);
		fa = (sa < FlushEps && sa > -FlushEps) ? '0 : sa;
		fb = (sb < FlushEps && sb > -FlushEps) ? '0 : sb;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dA_s4 <= fa;
			dB_s4 <= fb;
			cross_s4 <= (fa > 0 && fb < 0) || (fa < 0 && fb > 0);
		end
	end

	// stage 5: magnitudes, divider input
	logic [DistW-1:0] aA, aB, num_s5, den_s5;
	assign aA = dA_s4[DistW-1] ? DistW'(-dA_s4) : DistW'(dA_s4);
	assign aB = dB_s4[DistW-1] ? DistW'(-dB_s4) : DistW'(dB_s4);
	always_ff @(posedge clk) begin
		if (en) begin
			num_s5 <= cross_s4 ? aA : '0;
			den_s5 <= cross_s4 ? aA + aB : DistW'(1);
		end
	end

	// delay line alongside divider (stage 5 plus DivLat stages)
	localparam int DL = DivLat + 1;
	logic signed [CoordW-1:0] dpos_q [DL][3], dva_q [DL][3];
	logic dcr_q [DL];
	always_ff @(posedge clk) begin
		if (en) begin
			dpos_q[0] <= pos_s4;
			dva_q[0] <= va_s4;
			dcr_q[0] <= cross_s4;
			for (int k = 1; k < DL; k++) begin
				dpos_q[k] <= dpos_q[k-1];
				dva_q[k] <= dva_q[k-1];
				dcr_q[k] <= dcr_q[k-1];
			end
		end
	end

	logic [RatioBits-1:0] r_d;
	mcap_div u_div (.clk(clk), .en(en), .num(num_s5), .den(den_s5), .quo(r_d));

	// stage L1: (pos - va) * r
	logic signed [CoordW-1:0] pos_l1 [3], va_l1 [3];
	logic signed [63:0] pr_l1 [3];
	logic cr_l1;
	// stage L2: look, dis
	logic signed [CoordW-1:0] pos_l2 [3], lk_l2 [3];
	logic cr_l2;
	// stage L3: dis * N
	logic signed [CoordW-1:0] pos_l3 [3], lk_l3 [3];
	logic signed [64:0] pd_l3 [3];
	logic cr_l3;
	// stage L4: a
	logic signed [CoordW-1:0] pos_l4 [3], lk_l4 [3], a_l4;
	logic cr_l4;
	// stage L5: a*N
	logic signed [CoordW-1:0] pos_l5 [3], lk_l5 [3];
	logic signed [63:0] an_l5 [3];
	logic cr_l5;
	// stage L6: output register
	logic signed [CoordW-1:0] lk_o [3], np_o [3];
	logic cr_o;

	logic signed [DistW-1:0] sdis;
	assign sdis = DistW'(pd_l3[0] >>> 16) + DistW'(pd_l3[1] >>> 16) +
		DistW'(pd_l3[2] >>> 16);

	always_ff @(posedge clk) begin
		if (en) begin
			cr_l1 <= dcr_q[DL-1];
			cr_l2 <= cr_l1;
			cr_l3 <= cr_l2;
			cr_l4 <= cr_l3;
			cr_l5 <= cr_l4;
			cr_o <= cr_l5;
			a_l4 <= sat32(70'(sdis));
			for (int i = 0; i < 3; i++) begin
				pos_l1[i] <= dpos_q[DL-1][i];
				va_l1[i] <= dva_q[DL-1][i];
				pr_l1[i] <= (33'(dpos_q[DL-1][i]) - 33'(dva_q[DL-1][i])) *
					$signed({1'b0, r_d});
				pos_l2[i] <= pos_l1[i];
				lk_l2[i] <= sat32(70'(va_l1[i]) + 70'(pr_l1[i] >>> RatioBits));
				pos_l3[i] <= pos_l2[i];
				lk_l3[i] <= lk_l2[i];
				pd_l3[i] <= (33'(pos_l2[i]) - 33'(lk_l2[i])) * nrm[i];
				pos_l4[i] <= pos_l3[i];
				lk_l4[i] <= lk_l3[i];
				pos_l5[i] <= pos_l4[i];
				lk_l5[i] <= lk_l4[i];
				an_l5[i] <= a_l4 * nrm[i];
				lk_o[i] <= cr_l5 ? lk_l5[i] : '0;
				np_o[i] <= cr_l5 ? sat32(70'(pos_l5[i]) - 70'(an_l5[i] >>> 15)) : '0;
			end
		end
	end

	assign m_axis_tdata = {np_o[2], np_o[1], np_o[0], lk_o[2], lk_o[1], lk_o[0]};
	assign m_axis_tuser = cr_o;
endmodule
`default_nettype wire
